// ----- design/dtf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtf_pkg
// Shared constants, codes and stage records of the degree trig function unit.
// ----------------------------------------------------------------------------
package dtf_pkg;

    // Field widths and number formats
    localparam int OP_W         = 3;
    localparam int ANGLE_W      = 32;
    localparam int VALUE_W      = 32;
    localparam int FRAC_BITS    = 16;
    localparam int SERIES_TERMS = 17;
    localparam int IFRAC        = 30;

    // Angle reduction: integer degrees, remainder in [0, 90)
    localparam int DEG_INT_W = ANGLE_W - FRAC_BITS;
    localparam int QUAD_DEG  = 90;
    localparam int REM_INT_W = 7;
    localparam int R_W       = REM_INT_W + FRAC_BITS;
    localparam logic [DEG_INT_W-1:0] RECIP_90 =
        DEG_INT_W'((64'd1 << DEG_INT_W) / 64'd90);

    // Degrees to radians, pi/180 with 32 fraction bits
    localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
    localparam logic [63:0] DEG_Q32 = (PI_Q60 / 64'd180 + (64'd1 << 27)) >> 28;
    localparam int DEG_W   = 32;
    localparam int T_SHIFT = 32 - IFRAC + FRAC_BITS;

    // Series formats
    localparam int T_W    = 31;
    localparam int T2_W   = 32;
    localparam int TERM_W = 33;
    localparam int SUM_W  = 34;
    localparam int DIV_W  = 13;
    localparam int SER_STAGES = 3 * (SERIES_TERMS - 1);
    localparam logic [TERM_W-1:0] ONE_TERM = TERM_W'(64'd1 << IFRAC);
    localparam logic [63:0] SNAP_HI = ((64'd999 << IFRAC) + 64'd500) / 64'd1000;
    localparam logic [63:0] SNAP_LO = ((64'd1 << IFRAC) + 64'd500) / 64'd1000;
    localparam logic signed [SUM_W-1:0] SNAP_HI_S = SUM_W'(SNAP_HI);
    localparam logic signed [SUM_W-1:0] SNAP_LO_S = SUM_W'(SNAP_LO);

    // Quotient formats
    localparam int MAG_W = IFRAC + 1;
    localparam int NUM_W = MAG_W + FRAC_BITS;

    // Queue between the front and the back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // Function select codes
    typedef enum logic [OP_W-1:0] {
        OP_SIN = 3'd0,
        OP_COS = 3'd1,
        OP_TAN = 3'd2,
        OP_COT = 3'd3,
        OP_SEC = 3'd4,
        OP_CSC = 3'd5
    } op_t;

    // Reduced angle handed from the front to the back
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [1:0]      quad;
        logic [T_W-1:0]  t;
    } angle_item_t;

    // One stage of the sine and cosine series lanes
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [1:0]               quad;
        logic [T2_W-1:0]          t2;
        logic [TERM_W-1:0]        term_s;
        logic [TERM_W-1:0]        term_c;
        logic [TERM_W-1:0]        aux_s;
        logic [TERM_W-1:0]        aux_c;
        logic signed [SUM_W-1:0]  sum_s;
        logic signed [SUM_W-1:0]  sum_c;
    } series_stage_t;

    // Quotient request from the series to the divider
    typedef struct packed {
        logic             undef;
        logic             neg;
        logic [MAG_W-1:0] nm;
        logic [MAG_W-1:0] dm;
    } quot_item_t;

    // One stage of the restoring divider
    typedef struct packed {
        logic             undef;
        logic             neg;
        logic [MAG_W-1:0] dm;
        logic [NUM_W-1:0] num;
        logic [MAG_W-1:0] rem;
        logic [NUM_W-1:0] quo;
    } div_stage_t;

endpackage
`default_nettype wire

// ----- design/dtf_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtf_front
// Accept beats, split the angle into quadrant and remainder, and convert the
// remainder to radians in three stages.
// ----------------------------------------------------------------------------
module dtf_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire logic [dtf_pkg::OP_W-1:0]    op,
    input  wire logic [dtf_pkg::ANGLE_W-1:0] angle_deg,
    output logic                            full,
    input  wire logic                       q_full,
    output logic                            q_push,
    output dtf_pkg::angle_item_t            q_data
);

    logic                                v1_reg, v2_reg, v3_reg;
    logic                                adv;
    logic                                take;

    logic [dtf_pkg::OP_W-1:0]            op1_reg, op2_reg;
    logic [dtf_pkg::DEG_INT_W-1:0]       h1_reg;
    logic [dtf_pkg::FRAC_BITS-1:0]       lo1_reg;
    logic [dtf_pkg::DEG_INT_W-1:0]       qe1_reg;
    logic [2*dtf_pkg::DEG_INT_W-1:0]     qe_prod;
    logic [dtf_pkg::DEG_INT_W-1:0]       qe_next;

    logic [dtf_pkg::DEG_INT_W+6:0]       k_prod;
    logic [dtf_pkg::DEG_INT_W-1:0]       rem_int;
    logic [dtf_pkg::DEG_INT_W-1:0]       k_next;
    logic [dtf_pkg::REM_INT_W-1:0]       rr_next;
    logic [1:0]                          quad2_reg;
    logic [dtf_pkg::R_W-1:0]             r2_reg;

    logic [dtf_pkg::R_W+dtf_pkg::DEG_W-1:0] t_prod;
    logic [dtf_pkg::R_W+dtf_pkg::DEG_W-1:0] t_round;
    dtf_pkg::angle_item_t                item3_reg;

    // Stall the whole front while its last stage cannot enter the queue
    assign adv    = !(v3_reg && q_full);
    assign full   = !adv;
    assign take   = push && adv;
    assign q_push = v3_reg && !q_full;
    assign q_data = item3_reg;

    // Estimate the integer degrees over 90 by a reciprocal
    assign qe_prod = angle_deg[dtf_pkg::ANGLE_W-1:dtf_pkg::FRAC_BITS] * dtf_pkg::RECIP_90;
    assign qe_next = qe_prod[2*dtf_pkg::DEG_INT_W-1:dtf_pkg::DEG_INT_W];

    // Correct the estimate by one and form the remainder
    always_comb
    begin
        k_prod  = qe1_reg * (dtf_pkg::DEG_INT_W+7)'(dtf_pkg::QUAD_DEG);
        rem_int = h1_reg - k_prod[dtf_pkg::DEG_INT_W-1:0];
        if (rem_int >= dtf_pkg::DEG_INT_W'(dtf_pkg::QUAD_DEG))
        begin
            k_next  = qe1_reg + 1'b1;
            rr_next = dtf_pkg::REM_INT_W'(rem_int - dtf_pkg::DEG_INT_W'(dtf_pkg::QUAD_DEG));
        end
        else
        begin
            k_next  = qe1_reg;
            rr_next = dtf_pkg::REM_INT_W'(rem_int);
        end
    end

    // Scale the remainder to radians, rounded to nearest
    assign t_prod  = r2_reg * dtf_pkg::DEG_Q32[dtf_pkg::DEG_W-1:0];
    assign t_round = t_prod + ((dtf_pkg::R_W+dtf_pkg::DEG_W)'(1) << (dtf_pkg::T_SHIFT - 1));

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= push;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op1_reg <= op;
            h1_reg  <= angle_deg[dtf_pkg::ANGLE_W-1:dtf_pkg::FRAC_BITS];
            lo1_reg <= angle_deg[dtf_pkg::FRAC_BITS-1:0];
            qe1_reg <= qe_next;
        end
        if (adv)
        begin
            op2_reg        <= op1_reg;
            quad2_reg      <= k_next[1:0];
            r2_reg         <= {rr_next, lo1_reg};
            item3_reg.op   <= op2_reg;
            item3_reg.quad <= quad2_reg;
            item3_reg.t    <= t_round[dtf_pkg::T_SHIFT +: dtf_pkg::T_W];
        end
    end

endmodule
`default_nettype wire

// ----- design/dtf_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtf_queue
// Short first-in first-out queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module dtf_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  dtf_pkg::angle_item_t      wdata,
    output logic                      full,
    input  wire logic                 pop,
    output dtf_pkg::angle_item_t      rdata,
    output logic                      empty
);

    dtf_pkg::angle_item_t             mem_reg [dtf_pkg::QDEPTH];
    logic [dtf_pkg::QPTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [dtf_pkg::QCNT_W-1:0]       count_reg;
    logic                             do_push, do_pop;

    assign full    = (count_reg == dtf_pkg::QCNT_W'(dtf_pkg::QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Move the pointers and the fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Store the beat
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule
`default_nettype wire

// ----- design/dtf_series.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtf_series
// Pipelined sine and cosine Taylor series, snap, quadrant identities and
// selection of the quotient operands. Three stages per series term.
// ----------------------------------------------------------------------------
module dtf_series (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 adv,
    input  wire logic                 q_empty,
    input  dtf_pkg::angle_item_t      q_data,
    output logic                      q_pop,
    output logic                      out_valid,
    output dtf_pkg::quot_item_t       out_item
);

    localparam int NST = dtf_pkg::SER_STAGES;

    logic                             vl_reg;
    dtf_pkg::angle_item_t             load_reg;
    logic [2*dtf_pkg::T_W-1:0]        tt_prod;
    logic                             v_reg  [NST+1];
    dtf_pkg::series_stage_t           st_reg [NST+1];
    dtf_pkg::series_stage_t           st_next[NST+1];
    logic                             vo_reg;
    dtf_pkg::quot_item_t              out_reg;

    logic signed [31:0]               s_snap, c_snap, sx, cx, num, den;
    logic [31:0]                      num_abs, den_abs;

    assign q_pop     = adv && !q_empty;
    assign out_valid = vo_reg;
    assign out_item  = out_reg;

    // Square the angle and seed both lanes
    assign tt_prod = load_reg.t * load_reg.t;
    always_comb
    begin
        st_next[0].op     = load_reg.op;
        st_next[0].quad   = load_reg.quad;
        st_next[0].t2     = tt_prod[dtf_pkg::IFRAC +: dtf_pkg::T2_W];
        st_next[0].term_s = dtf_pkg::TERM_W'(load_reg.t);
        st_next[0].term_c = dtf_pkg::ONE_TERM;
        st_next[0].aux_s  = '0;
        st_next[0].aux_c  = '0;
        st_next[0].sum_s  = dtf_pkg::SUM_W'(load_reg.t);
        st_next[0].sum_c  = dtf_pkg::SUM_W'(dtf_pkg::ONE_TERM);
    end

    // Three stages per term: multiply by t2, reciprocal estimate, correct and sum
    for (genvar n = 1; n < dtf_pkg::SERIES_TERMS; n++)
    begin : g_term
        localparam int B   = 3 * (n - 1);
        localparam int DS  = (2 * n) * (2 * n + 1);
        localparam int DC  = (2 * n - 1) * (2 * n);
        localparam logic [dtf_pkg::TERM_W-1:0] MS =
            dtf_pkg::TERM_W'((64'd1 << dtf_pkg::TERM_W) / DS);
        localparam logic [dtf_pkg::TERM_W-1:0] MC =
            dtf_pkg::TERM_W'((64'd1 << dtf_pkg::TERM_W) / DC);
        localparam logic [dtf_pkg::DIV_W-1:0] DSV = dtf_pkg::DIV_W'(DS);
        localparam logic [dtf_pkg::DIV_W-1:0] DCV = dtf_pkg::DIV_W'(DC);

        logic [dtf_pkg::TERM_W+dtf_pkg::T2_W-1:0]   xs_prod, xc_prod;
        logic [2*dtf_pkg::TERM_W-1:0]               es_prod, ec_prod;
        logic [dtf_pkg::TERM_W+dtf_pkg::DIV_W-1:0]  bs_prod, bc_prod;
        logic [dtf_pkg::TERM_W-1:0]                 rs, rc, ts, tc;

        // Multiply the previous term by t2
        always_comb
        begin
            xs_prod = st_reg[B].term_s * st_reg[B].t2;
            xc_prod = st_reg[B].term_c * st_reg[B].t2;
            st_next[B+1]        = st_reg[B];
            st_next[B+1].term_s = xs_prod[dtf_pkg::IFRAC +: dtf_pkg::TERM_W];
            st_next[B+1].term_c = xc_prod[dtf_pkg::IFRAC +: dtf_pkg::TERM_W];
        end

        // Estimate the quotient by the reciprocal of the term divisor
        always_comb
        begin
            es_prod = st_reg[B+1].term_s * MS;
            ec_prod = st_reg[B+1].term_c * MC;
            st_next[B+2]       = st_reg[B+1];
            st_next[B+2].aux_s = es_prod[dtf_pkg::TERM_W +: dtf_pkg::TERM_W];
            st_next[B+2].aux_c = ec_prod[dtf_pkg::TERM_W +: dtf_pkg::TERM_W];
        end

        // Correct the estimate by one, then add or subtract the term
        always_comb
        begin
            bs_prod = st_reg[B+2].aux_s * DSV;
            bc_prod = st_reg[B+2].aux_c * DCV;
            rs = st_reg[B+2].term_s - bs_prod[dtf_pkg::TERM_W-1:0];
            rc = st_reg[B+2].term_c - bc_prod[dtf_pkg::TERM_W-1:0];
            ts = (rs >= dtf_pkg::TERM_W'(DSV)) ? st_reg[B+2].aux_s + 1'b1
                                                : st_reg[B+2].aux_s;
            tc = (rc >= dtf_pkg::TERM_W'(DCV)) ? st_reg[B+2].aux_c + 1'b1
                                                : st_reg[B+2].aux_c;
            st_next[B+3]        = st_reg[B+2];
            st_next[B+3].term_s = ts;
            st_next[B+3].term_c = tc;
            if (n % 2 == 1)
            begin
                st_next[B+3].sum_s = st_reg[B+2].sum_s - $signed({1'b0, ts});
                st_next[B+3].sum_c = st_reg[B+2].sum_c - $signed({1'b0, tc});
            end
            else
            begin
                st_next[B+3].sum_s = st_reg[B+2].sum_s + $signed({1'b0, ts});
                st_next[B+3].sum_c = st_reg[B+2].sum_c + $signed({1'b0, tc});
            end
        end
    end

    // Snap near 0 and 1, apply the quadrant and pick numerator and denominator
    always_comb
    begin
        if (st_reg[NST].sum_s >= dtf_pkg::SNAP_HI_S)
            s_snap = 32'sd1 <<< dtf_pkg::IFRAC;
        else if (st_reg[NST].sum_s <= dtf_pkg::SNAP_LO_S)
            s_snap = '0;
        else
            s_snap = 32'(st_reg[NST].sum_s);
        if (st_reg[NST].sum_c >= dtf_pkg::SNAP_HI_S)
            c_snap = 32'sd1 <<< dtf_pkg::IFRAC;
        else if (st_reg[NST].sum_c <= dtf_pkg::SNAP_LO_S)
            c_snap = '0;
        else
            c_snap = 32'(st_reg[NST].sum_c);

        case (st_reg[NST].quad)
            2'd0:    begin sx = s_snap;  cx = c_snap;  end
            2'd1:    begin sx = c_snap;  cx = -s_snap; end
            2'd2:    begin sx = -s_snap; cx = -c_snap; end
            default: begin sx = -c_snap; cx = s_snap;  end
        endcase

        case (dtf_pkg::op_t'(st_reg[NST].op))
            dtf_pkg::OP_SIN: begin num = sx; den = 32'sd1 <<< dtf_pkg::IFRAC; end
            dtf_pkg::OP_COS: begin num = cx; den = 32'sd1 <<< dtf_pkg::IFRAC; end
            dtf_pkg::OP_TAN: begin num = sx; den = cx; end
            dtf_pkg::OP_COT: begin num = cx; den = sx; end
            dtf_pkg::OP_SEC: begin num = 32'sd1 <<< dtf_pkg::IFRAC; den = cx; end
            dtf_pkg::OP_CSC: begin num = 32'sd1 <<< dtf_pkg::IFRAC; den = sx; end
            default:         begin num = '0; den = '0; end
        endcase

        num_abs = num[31] ? 32'(-num) : 32'(num);
        den_abs = den[31] ? 32'(-den) : 32'(den);
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vl_reg <= 1'b0;
            vo_reg <= 1'b0;
            for (int i = 0; i <= NST; i++)
                v_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vl_reg   <= !q_empty;
            v_reg[0] <= vl_reg;
            for (int i = 1; i <= NST; i++)
                v_reg[i] <= v_reg[i-1];
            vo_reg   <= v_reg[NST];
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            load_reg <= q_data;
            for (int i = 0; i <= NST; i++)
                st_reg[i] <= st_next[i];
            out_reg.undef <= (den == '0);
            out_reg.neg   <= num[31] ^ den[31];
            out_reg.nm    <= num_abs[dtf_pkg::MAG_W-1:0];
            out_reg.dm    <= den_abs[dtf_pkg::MAG_W-1:0];
        end
    end

endmodule
`default_nettype wire

// ----- design/dtf_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtf_div
// Pipelined restoring divider, one quotient bit per stage, then rounding,
// saturation and a two-entry output queue that sets the back-end stall.
// ----------------------------------------------------------------------------
module dtf_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  dtf_pkg::quot_item_t               in_item,
    output logic                              adv,
    input  wire logic                         pop,
    output logic                              empty,
    output logic signed [dtf_pkg::VALUE_W-1:0] value,
    output logic                              undefined
);

    localparam int NW = dtf_pkg::NUM_W;

    logic                         v_reg  [NW+1];
    dtf_pkg::div_stage_t          st_reg [NW+1];
    dtf_pkg::div_stage_t          st_next[NW+1];

    logic [NW-1:0]                mag;
    logic [dtf_pkg::VALUE_W-1:0]  res_val;
    logic                         res_undef;

    logic [dtf_pkg::VALUE_W-1:0]  e0_val_reg, e1_val_reg;
    logic                         e0_und_reg, e1_und_reg;
    logic [1:0]                   ocount_reg;
    logic                         do_push, do_pop;
    logic                         push_head;

    // Hold the back end while the output queue is full
    assign adv       = (ocount_reg != 2'd2);
    assign empty     = (ocount_reg == 2'd0);
    assign value     = e0_val_reg;
    assign undefined = e0_und_reg;
    assign do_push   = v_reg[NW] && adv;
    assign do_pop    = pop && !empty;
    assign push_head = do_push && (ocount_reg == 2'd0 || (ocount_reg == 2'd1 && do_pop));

    // Load the scaled numerator with half the divisor for rounding
    always_comb
    begin
        st_next[0].undef = in_item.undef;
        st_next[0].neg   = in_item.neg;
        st_next[0].dm    = in_item.dm;
        st_next[0].num   = {in_item.nm, dtf_pkg::FRAC_BITS'(0)}
                         + NW'(in_item.dm >> 1);
        st_next[0].rem   = '0;
        st_next[0].quo   = '0;
    end

    // One quotient bit per stage
    for (genvar i = 1; i <= NW; i++)
    begin : g_bit
        logic [dtf_pkg::MAG_W:0] trial;
        always_comb
        begin
            trial       = {st_reg[i-1].rem, st_reg[i-1].num[NW-1]};
            st_next[i]  = st_reg[i-1];
            st_next[i].num = st_reg[i-1].num << 1;
            if (trial >= {1'b0, st_reg[i-1].dm})
            begin
                st_next[i].rem = dtf_pkg::MAG_W'(trial - {1'b0, st_reg[i-1].dm});
                st_next[i].quo = {st_reg[i-1].quo[NW-2:0], 1'b1};
            end
            else
            begin
                st_next[i].rem = trial[dtf_pkg::MAG_W-1:0];
                st_next[i].quo = {st_reg[i-1].quo[NW-2:0], 1'b0};
            end
        end
    end

    // Apply the sign and saturate to the output range
    always_comb
    begin
        mag       = st_reg[NW].quo;
        res_undef = st_reg[NW].undef;
        if (st_reg[NW].undef || mag == '0)
            res_val = '0;
        else if (st_reg[NW].neg)
        begin
            if (mag >= (NW'(1) << (dtf_pkg::VALUE_W - 1)))
                res_val = {1'b1, {(dtf_pkg::VALUE_W-1){1'b0}}};
            else
                res_val = 32'(-mag[dtf_pkg::VALUE_W-1:0]);
        end
        else
        begin
            if (mag > NW'({1'b0, {(dtf_pkg::VALUE_W-1){1'b1}}}))
                res_val = {1'b0, {(dtf_pkg::VALUE_W-1){1'b1}}};
            else
                res_val = mag[dtf_pkg::VALUE_W-1:0];
        end
    end

    // Advance the valid bits and the queue count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NW; i++)
                v_reg[i] <= 1'b0;
            ocount_reg <= 2'd0;
        end
        else
        begin
            if (adv)
            begin
                v_reg[0] <= in_valid;
                for (int i = 1; i <= NW; i++)
                    v_reg[i] <= v_reg[i-1];
            end
            if (do_push && !do_pop)
                ocount_reg <= ocount_reg + 1'b1;
            else if (do_pop && !do_push)
                ocount_reg <= ocount_reg - 1'b1;
        end
    end

    // Advance the divider payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i <= NW; i++)
                st_reg[i] <= st_next[i];
        end
    end

    // Shift the output queue on pop and write the new beat at the head when that slot is free, else behind it
    always_ff @(posedge clk)
    begin
        if (push_head)
        begin
            e0_val_reg <= res_val;
            e0_und_reg <= res_undef;
        end
        else if (do_pop)
        begin
            e0_val_reg <= e1_val_reg;
            e0_und_reg <= e1_und_reg;
        end
        if (do_push && !push_head)
        begin
            e1_val_reg <= res_val;
            e1_und_reg <= res_undef;
        end
    end

endmodule
`default_nettype wire

// ----- design/degree_trig_function_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// degree_trig_function_unit
// Sine, cosine, tangent, cotangent, secant and cosecant of an angle in
// degrees, by quadrant reduction and a pipelined Taylor series.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------
//  input    | push / full        | op[2:0], angle_deg[31:0]
//  result   | pop / empty        | value[31:0] signed, undefined
//
// One beat is taken per cycle while full is low, one result leaves per cycle
// while empty is low and pop is high. A result passes three front stages, one
// queue entry, 51 series stages (load, seed, three per term for sixteen terms,
// operand select), 48 divider stages (load and 47 quotient bits), output queue.
// Reset clears all valid bits and both queues; payload keeps no reset.
// A stalled result stops the back end only; the front keeps filling the
// four-entry queue and raises full when it cannot place its last stage.
// ----------------------------------------------------------------------------
module degree_trig_function_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [dtf_pkg::OP_W-1:0]      op,
    input  wire logic [dtf_pkg::ANGLE_W-1:0]   angle_deg,
    output logic                               empty,
    input  wire logic                          pop,
    output logic signed [dtf_pkg::VALUE_W-1:0] value,
    output logic                               undefined
);

    logic                   q_push, q_full, q_pop, q_empty;
    dtf_pkg::angle_item_t   q_wdata, q_rdata;
    logic                   adv;
    logic                   ser_valid;
    dtf_pkg::quot_item_t    ser_item;

    // Accept and reduce the angle
    dtf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .op        (op),
        .angle_deg (angle_deg),
        .full      (full),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    // Decouple front and back
    dtf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    // Evaluate the series and pick the quotient operands
    dtf_series u_series (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .q_empty   (q_empty),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .out_valid (ser_valid),
        .out_item  (ser_item)
    );

    // Divide, saturate and queue the results
    dtf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ser_valid),
        .in_item   (ser_item),
        .adv       (adv),
        .pop       (pop),
        .empty     (empty),
        .value     (value),
        .undefined (undefined)
    );

endmodule
`default_nettype wire

// ----- design/dtf_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtf_checker
// Port-level checks of the degree trig function unit, bound to the top level.
// ----------------------------------------------------------------------------
module dtf_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          empty,
    input wire logic                          pop,
    input wire logic signed [dtf_pkg::VALUE_W-1:0] value,
    input wire logic                          undefined
);

    // Hold a waiting result until it is taken
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result dropped while stalled");

    // Keep a stalled result stable
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(value) && $stable(undefined)))
        else $error("stalled result changed");

    // Drive zero with the undefined flag
    a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && undefined) |-> (value == '0))
        else $error("undefined result is not zero");

    // Bound the magnitude by the smallest nonzero denominator
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((value < 32'sh0400_0000) && (value > -32'sh0400_0000)))
        else $error("result out of range");

    // Show no results during reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> empty)
        else $error("result present during reset");

endmodule

bind degree_trig_function_unit dtf_checker u_dtf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop       (pop),
    .value     (value),
    .undefined (undefined)
);
`default_nettype wire

// ----- sim/degree_trig_function_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// degree_trig_function_unit_tb
// Drives op/angle beats through the queue-style input and pops results at
// random rates. A bit-exact trig model predicts each result and checks the
// popped value and undefined flag in order.
// ----------------------------------------------------------------------------

class trig_scoreboard;
    typedef struct {
        logic [31:0] value;
        logic        undefined;
    } trig_result_t;

    trig_result_t pending_results[$];
    int           error_count;
    int           checked_count;
    int           undef_count;

    localparam logic [63:0] ONE_Q30  = 64'd1 << 30;
    localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
    localparam logic [63:0] RAD_Q32  = (PI_Q60 / 64'd180 + (64'd1 << 27)) >> 28;
    localparam longint      NEAR_ONE = longint'(((64'd999 << 30) + 64'd500) / 64'd1000);
    localparam longint      NEAR_ZERO = longint'(((64'd1 << 30) + 64'd500) / 64'd1000);

    // Taylor series of sine or cosine, snapped near 0 and 1
    function automatic longint taylor_sum(logic [63:0] t, bit cosine);
        logic [63:0] t2;
        logic [63:0] term;
        logic [63:0] d;
        longint      sum;
        t2   = (t * t) >> 30;
        term = cosine ? ONE_Q30 : t;
        sum  = longint'(term);
        for (int n = 1; n < 17; n++)
        begin
            d    = cosine ? 64'((2 * n - 1) * (2 * n)) : 64'((2 * n) * (2 * n + 1));
            term = ((term * t2) >> 30) / d;
            if (n & 1)
                sum -= longint'(term);
            else
                sum += longint'(term);
        end
        if (sum >= NEAR_ONE)
            return longint'(ONE_Q30);
        if (sum <= NEAR_ZERO)
            return 0;
        return sum;
    endfunction

    // Predict one result from an accepted beat
    function void note_input(logic [2:0] op, logic [31:0] angle);
        logic [63:0]  unit;
        logic [63:0]  k;
        logic [63:0]  r;
        logic [63:0]  t;
        logic [63:0]  nm;
        logic [63:0]  dm;
        logic [63:0]  mag;
        longint       s;
        longint       c;
        longint       sx;
        longint       cx;
        longint       num;
        longint       den;
        bit           neg;
        trig_result_t res;
        unit = 64'd90 << 16;
        k    = {32'd0, angle} / unit;
        r    = {32'd0, angle} - k * unit;
        t    = ((r << 14) * RAD_Q32 + (64'd1 << 31)) >> 32;
        s    = taylor_sum(t, 1'b0);
        c    = taylor_sum(t, 1'b1);
        case (k[1:0])
            2'd0:    begin sx = s;  cx = c;  end
            2'd1:    begin sx = c;  cx = -s; end
            2'd2:    begin sx = -s; cx = -c; end
            default: begin sx = -c; cx = s;  end
        endcase
        case (op)
            dtf_pkg::OP_SIN: begin num = sx; den = longint'(ONE_Q30); end
            dtf_pkg::OP_COS: begin num = cx; den = longint'(ONE_Q30); end
            dtf_pkg::OP_TAN: begin num = sx; den = cx; end
            dtf_pkg::OP_COT: begin num = cx; den = sx; end
            dtf_pkg::OP_SEC: begin num = longint'(ONE_Q30); den = cx; end
            dtf_pkg::OP_CSC: begin num = longint'(ONE_Q30); den = sx; end
            default:         begin num = 0; den = 0; end
        endcase
        if (den == 0)
        begin
            res.value     = '0;
            res.undefined = 1'b1;
        end
        else
        begin
            nm  = 64'(num < 0 ? -num : num);
            dm  = 64'(den < 0 ? -den : den);
            neg = (num < 0) != (den < 0);
            mag = ((nm << 16) + dm / 2) / dm;
            res.undefined = 1'b0;
            if (mag == 0)
                res.value = '0;
            else if (neg)
                res.value = (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - mag);
            else
                res.value = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        end
        pending_results.push_back(res);
    endfunction

    // Compare a popped beat with the oldest prediction
    function void check_result(logic [31:0] value, logic undefined);
        trig_result_t exp_res;
        if (pending_results.size() == 0)
        begin
            $error("result beat with no prediction: value=%h undefined=%b", value, undefined);
            error_count++;
            return;
        end
        exp_res = pending_results.pop_front();
        checked_count++;
        if (undefined)
            undef_count++;
        if (value !== exp_res.value)
        begin
            $error("value: expected %h, actual %h", exp_res.value, value);
            error_count++;
        end
        if (undefined !== exp_res.undefined)
        begin
            $error("undefined: expected %b, actual %b", exp_res.undefined, undefined);
            error_count++;
        end
    endfunction
endclass

module degree_trig_function_unit_tb;

    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;
    localparam int         RANDOM_BEATS = 1725;
    localparam int         HOLD_OFF_CYCLES = 400;

    logic                               clk;
    logic                               rst_n;
    logic                               push;
    logic                               full;
    logic [dtf_pkg::OP_W-1:0]           op;
    logic [dtf_pkg::ANGLE_W-1:0]        angle_deg;
    logic                               empty;
    logic                               pop;
    logic signed [dtf_pkg::VALUE_W-1:0] value;
    logic                               undefined;

    trig_scoreboard trig_sb;
    int             sent_count;
    bit             no_idle;
    bit             hold_off_done;

    degree_trig_function_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .op        (op),
        .angle_deg (angle_deg),
        .empty     (empty),
        .pop       (pop),
        .value     (value),
        .undefined (undefined)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Mostly short gaps, a few long ones
    function automatic int random_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one beat and hold it until accepted
    task automatic send_angle(logic [2:0] sel, logic [31:0] ang);
        bit taken;
        push      <= 1'b1;
        op        <= sel;
        angle_deg <= ang;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !full;
            @(posedge clk);
        end
        trig_sb.note_input(sel, ang);
        sent_count++;
    endtask

    // Drop push for a number of cycles
    task automatic idle_input(int cycles);
        if (cycles > 0)
        begin
            push <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Random angle: full range, quadrant edges, near edges, below 90 and below 360 degrees
    function automatic logic [31:0] random_angle();
        logic [31:0] edge90;
        edge90 = ($urandom_range(0, 728) * 90) << 16;
        case ($urandom_range(0, 4))
            0:       return $urandom();
            1:       return edge90;
            2:       return edge90 + $urandom_range(0, 80) - 40;
            3:       return $urandom_range(0, 32'h005A_0000);
            default: return $urandom_range(0, 32'h0168_0000);
        endcase
    endfunction

    // Pop process: random stalls plus one long hold-off
    initial
    begin
        int stall_left;
        stall_left = 0;
        hold_off_done = 1'b0;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (pop && !empty)
                trig_sb.check_result(value, undefined);
            @(posedge clk);
            if (!hold_off_done && trig_sb.checked_count >= 300)
            begin
                hold_off_done = 1'b1;
                stall_left = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 99) < 25)
            begin
                stall_left = random_gap();
                pop <= (stall_left == 0);
            end
            else
                pop <= 1'b1;
        end
    end

    // Main stimulus
    initial
    begin
        logic [2:0] sel;
        int         wait_cycles;
        trig_sb    = new();
        sent_count = 0;
        no_idle    = 1'b0;
        rst_n      = 1'b0;
        push       = 1'b0;
        op         = '0;
        angle_deg  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Each select at a quadrant edge, then at 45 degrees
        for (int i = 0; i < 8; i++)
            send_angle(3'(i), (i * 90) << 16);
        for (int i = 0; i < 8; i++)
            send_angle(3'(i), 32'd45 << 16);
        // Extremes, wraparound and near-edge remainders
        send_angle(dtf_pkg::OP_SIN, 32'hFFFF_FFFF);
        send_angle(dtf_pkg::OP_COT, 32'hFFFF_FFFF);
        send_angle(dtf_pkg::OP_TAN, 32'd0);
        send_angle(dtf_pkg::OP_SEC, 32'd450 << 16);
        send_angle(dtf_pkg::OP_CSC, 32'd720 << 16);
        send_angle(dtf_pkg::OP_COS, (32'd90 << 16) - 1);
        send_angle(dtf_pkg::OP_TAN, (32'd90 << 16) - 1);
        send_angle(dtf_pkg::OP_SIN, 32'd1);

        // Random part; periodic stretches without idling
        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            if (i % 250 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            if (i == 900)
            begin
                // Pause until the pipe drains
                idle_input(1);
                while (trig_sb.pending_results.size() != 0)
                    @(posedge clk);
            end
            sel = ($urandom_range(0, 19) == 0) ? ($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B)
                                               : 3'($urandom_range(0, 5));
            send_angle(sel, random_angle());
            if (!no_idle)
                idle_input(random_gap());
        end
        push <= 1'b0;

        // Drain, then let the latency pass
        wait_cycles = 0;
        while (trig_sb.pending_results.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (200) @(posedge clk);

        $display("Sent %0d beats over all six functions, spare selects, quadrant edges",
                 sent_count);
        $display("and full-range angles; checked %0d results, %0d undefined.",
                 trig_sb.checked_count, trig_sb.undef_count);
        if (trig_sb.error_count == 0 && trig_sb.pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Run limit
    initial
    begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
